// ===== src/hshs_pkg.sv =====
// Package with types, constants and helpers for the hard-stop homing sequencer.
`timescale 1ns / 1ps

package hshs_pkg;

  // Counter, velocity, threshold, tick and config index widths.
  localparam int COUNT_WIDTH = 16;
  localparam int VEL_WIDTH   = 32;
  localparam int THR_WIDTH   = 31;
  localparam int TICK_WIDTH  = 16;
  localparam int CFG_IDX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOME_VELOCITY  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STILL_THRESH   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STILL_DWELL    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BACKOFF_DWELL  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT        = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [THR_WIDTH-1:0]  STILL_THRESH_RST  = 31'd655;
  localparam logic [TICK_WIDTH-1:0] STILL_DWELL_RST   = 16'd1000;
  localparam logic [TICK_WIDTH-1:0] BACKOFF_DWELL_RST = 16'd1000;
  localparam logic [TICK_WIDTH-1:0] TIMEOUT_RST       = 16'd30000;

  // Status codes as reported on the result word.
  localparam logic [1:0] STATUS_IDLE    = 2'd0;
  localparam logic [1:0] STATUS_RUNNING = 2'd1;
  localparam logic [1:0] STATUS_DONE    = 2'd2;
  localparam logic [1:0] STATUS_FAILED  = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Sequencer phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_RUNNING = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_FAILED  = 4'b1000
  } phase_t;

  // One control tick.
  typedef struct packed {
    logic                        enable;
    logic                        clear;
    logic signed [VEL_WIDTH-1:0] measured_velocity;
    logic                        overcurrent_trip;
  } tick_t;

  // One result word.
  typedef struct packed {
    logic                        active;
    logic                        drive_req;
    logic signed [VEL_WIDTH-1:0] velocity_command;
    logic                        use_slew;
    logic                        ramp_restart;
    logic                        datum_latch;
    logic                        consume_trip;
    logic                        completed;
    logic [1:0]                  status;
  } result_t;

  // Saturating counter increment.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  // Map the one-hot phase to its status code.
  function automatic logic [1:0] phase_code(input phase_t p);
    case (p)
      PH_RUNNING: phase_code = STATUS_RUNNING;
      PH_DONE:    phase_code = STATUS_DONE;
      PH_FAILED:  phase_code = STATUS_FAILED;
      default:    phase_code = STATUS_IDLE;
    endcase
  endfunction

endpackage

// ===== src/hard_stop_homing_sequencer_unit.sv =====
// Top level of the sensorless hard-stop homing sequencer.
`timescale 1ns / 1ps

// Usage: each tick word on the tick channel is one control tick (enable,
// clear, measured velocity and the latched over-current trip flag). For each
// tick word the block returns exactly one result word on the result channel,
// in order. A word moves at a clock edge where valid is high and stall is low.
// The tick word lands in an input register, and the sequencer logic then
// writes the result register. One tick word is taken every cycle while the
// receiver does not stall; the rate is set by the single sequencer stage of
// compares and counter increments. When the receiver stalls, the result
// register holds its word and the input register fills; tick_stall rises
// only once both are full. The cfg channel is always ready and writes one
// register per handshake; writes must go only while the block is idle, which
// it does not enforce. Synchronous reset clears the sequencer to idle, zeroes
// its counters, empties both registers and restores the register defaults.
module hard_stop_homing_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 tick_valid,
  output logic                                 tick_stall,
  input  hshs_pkg::tick_t                      tick,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output hshs_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hshs_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [31:0]                          cfg_data
);
  import hshs_pkg::*;

  // Configuration registers.
  logic signed [VEL_WIDTH-1:0] approach_vel;
  logic [THR_WIDTH-1:0]        still_threshold;
  logic [TICK_WIDTH-1:0]       still_dwell_ticks;
  logic [TICK_WIDTH-1:0]       backoff_dwell_ticks;
  logic [TICK_WIDTH-1:0]       timeout_ticks;

  // Sequencer state.
  phase_t                 phase, phase_next;
  logic                   reversing, reversing_next;
  logic                   has_moved, has_moved_next;
  logic [COUNT_WIDTH-1:0] still_count, still_count_next;
  logic [COUNT_WIDTH-1:0] total_count, total_count_next;
  logic [COUNT_WIDTH-1:0] backoff_count, backoff_count_next;

  // Input register with its occupancy flag, and the next result word.
  logic    in_full;
  tick_t   in_word;
  result_t res_next;

  logic out_ready;
  logic fire;

  assign cfg_ready  = 1'b1;
  assign out_ready  = !result_valid || !result_stall;
  assign fire       = in_full && out_ready;
  assign tick_stall = in_full && !out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      approach_vel        <= '0;
      still_threshold     <= STILL_THRESH_RST;
      still_dwell_ticks   <= STILL_DWELL_RST;
      backoff_dwell_ticks <= BACKOFF_DWELL_RST;
      timeout_ticks       <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOME_VELOCITY: approach_vel        <= cfg_data;
        CFG_STILL_THRESH:  still_threshold     <= cfg_data[THR_WIDTH-1:0];
        CFG_STILL_DWELL:   still_dwell_ticks   <= cfg_data[TICK_WIDTH-1:0];
        CFG_BACKOFF_DWELL: backoff_dwell_ticks <= cfg_data[TICK_WIDTH-1:0];
        CFG_TIMEOUT:       timeout_ticks       <= cfg_data[TICK_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer step for the word held in the input register.
  always_comb begin
    logic [VEL_WIDTH-1:0]        mag;
    logic signed [VEL_WIDTH-1:0] neg_home;
    logic                        stop;
    logic                        timed_out;
    logic                        back_end;

    phase_next         = phase;
    reversing_next     = reversing;
    has_moved_next     = has_moved;
    still_count_next   = still_count;
    total_count_next   = total_count;
    backoff_count_next = backoff_count;
    res_next           = '0;

    // Absolute velocity; the most negative value maps to 2^31 unsigned.
    mag = in_word.measured_velocity[VEL_WIDTH-1] ?
          (~in_word.measured_velocity + 1'b1) : in_word.measured_velocity;

    // Saturated negation of the approach velocity for the back-off.
    neg_home = (approach_vel == {1'b1, {(VEL_WIDTH-1){1'b0}}}) ?
               {1'b0, {(VEL_WIDTH-1){1'b1}}} : -approach_vel;

    stop      = 1'b0;
    timed_out = 1'b0;
    back_end  = 1'b0;

    // Command handling: start, abort and clear.
    if (in_word.enable) begin
      if (phase == PH_IDLE) begin
        phase_next         = PH_RUNNING;
        still_count_next   = '0;
        total_count_next   = '0;
        has_moved_next     = 1'b0;
        reversing_next     = 1'b0;
        backoff_count_next = '0;
        res_next.consume_trip = 1'b1;
        res_next.ramp_restart = 1'b1;
      end
    end else begin
      if (phase == PH_RUNNING || in_word.clear) begin
        phase_next = PH_IDLE;
      end
    end

    // Running tick: approach or back-off.
    if (phase_next == PH_RUNNING) begin
      res_next.active  = 1'b1;
      total_count_next = sat_inc(total_count_next);
      if (!reversing_next) begin
        if (mag > {1'b0, still_threshold}) begin
          has_moved_next   = 1'b1;
          still_count_next = '0;
        end else if (has_moved_next) begin
          still_count_next = sat_inc(still_count_next);
        end
        stop = (32'(still_count_next) >= 32'(still_dwell_ticks)) ||
               in_word.overcurrent_trip;
        timed_out = 32'(total_count_next) >= 32'(timeout_ticks);
        if (stop) begin
          res_next.datum_latch = 1'b1;
          if (in_word.overcurrent_trip) begin
            res_next.consume_trip = 1'b1;
          end
          reversing_next        = 1'b1;
          backoff_count_next    = '0;
          res_next.ramp_restart = 1'b1;
          res_next.drive_req    = 1'b1;
        end else if (timed_out) begin
          phase_next = PH_FAILED;
        end else begin
          res_next.drive_req        = 1'b1;
          res_next.velocity_command = approach_vel;
          res_next.use_slew         = 1'b1;
        end
      end else begin
        backoff_count_next = sat_inc(backoff_count_next);
        back_end = 32'(backoff_count_next) >= 32'(backoff_dwell_ticks);
        if (back_end) begin
          phase_next         = PH_DONE;
          res_next.completed = 1'b1;
        end else begin
          res_next.drive_req        = 1'b1;
          res_next.velocity_command = neg_home;
          res_next.use_slew         = 1'b1;
        end
      end
    end

    res_next.status = phase_code(phase_next);
  end

  // Input register and its occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!tick_stall) begin
      in_full <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      in_word <= tick;
    end
  end

  // Sequencer state advances once per processed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      reversing     <= 1'b0;
      has_moved     <= 1'b0;
      still_count   <= '0;
      total_count   <= '0;
      backoff_count <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      reversing     <= reversing_next;
      has_moved     <= has_moved_next;
      still_count   <= still_count_next;
      total_count   <= total_count_next;
      backoff_count <= backoff_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

// ===== bench/hshs_homing_checker.sv =====
// Checker that predicts and compares result words of the hard-stop homing sequencer.
`timescale 1ns / 1ps

module hshs_homing_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick_valid,
  input  logic                               tick_stall,
  input  hshs_pkg::tick_t                    tick,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  hshs_pkg::result_t                  result,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [hshs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                        cfg_data,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 results_checked
);
  import hshs_pkg::*;

  // Shadow copy of the configuration registers.
  logic signed [VEL_WIDTH-1:0] home_vel;
  logic [THR_WIDTH-1:0]        still_thr;
  logic [TICK_WIDTH-1:0]       still_dwell;
  logic [TICK_WIDTH-1:0]       backoff_dwell;
  logic [TICK_WIDTH-1:0]       timeout_limit;

  // Shadow copy of the sequencer state.
  logic [1:0]             seq_status;
  logic                   reversing;
  logic                   has_moved;
  logic [COUNT_WIDTH-1:0] rest_cnt;
  logic [COUNT_WIDTH-1:0] run_ticks;
  logic [COUNT_WIDTH-1:0] retreat_cnt;

  result_t expected_q[$];
  result_t want;
  int      errors = 0;
  int      checked = 0;

  // Counter increment that sticks at the top value.
  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Advance the shadow state by one control tick and return the result word it gives.
  function automatic result_t homing_step(input tick_t t);
    result_t     r;
    logic [32:0] mag;
    r = '0;

    // Command handling: enable starts from idle, enable low aborts or clears.
    if (t.enable) begin
      if (seq_status == STATUS_IDLE) begin
        seq_status   = STATUS_RUNNING;
        rest_cnt     = '0;
        run_ticks    = '0;
        has_moved    = 1'b0;
        reversing    = 1'b0;
        retreat_cnt  = '0;
        r.consume_trip = 1'b1;
        r.ramp_restart = 1'b1;
      end
    end else if (t.clear || seq_status == STATUS_RUNNING) begin
      seq_status = STATUS_IDLE;
    end

    if (seq_status == STATUS_RUNNING) begin
      r.active  = 1'b1;
      run_ticks = bump(run_ticks);
      if (!reversing) begin
        // Approach: the stillness dwell only counts once the axis has moved.
        mag = {1'b0, t.measured_velocity};
        if (t.measured_velocity[VEL_WIDTH-1]) mag = 33'd0 - {1'b1, t.measured_velocity};
        if (mag > {2'b00, still_thr}) begin
          has_moved = 1'b1;
          rest_cnt  = '0;
        end else if (has_moved) begin
          rest_cnt = bump(rest_cnt);
        end
        // A found stop takes precedence over the timeout.
        if (rest_cnt >= still_dwell || t.overcurrent_trip) begin
          r.datum_latch = 1'b1;
          if (t.overcurrent_trip) r.consume_trip = 1'b1;
          reversing      = 1'b1;
          retreat_cnt    = '0;
          r.ramp_restart = 1'b1;
          r.drive_req    = 1'b1;
        end else if (run_ticks >= timeout_limit) begin
          seq_status = STATUS_FAILED;
        end else begin
          r.drive_req        = 1'b1;
          r.velocity_command = home_vel;
          r.use_slew         = 1'b1;
        end
      end else begin
        // Back-off at the negated home velocity, saturated at the positive limit.
        retreat_cnt = bump(retreat_cnt);
        if (retreat_cnt >= backoff_dwell) begin
          seq_status  = STATUS_DONE;
          r.completed = 1'b1;
        end else begin
          r.drive_req = 1'b1;
          if (home_vel == {1'b1, {(VEL_WIDTH-1){1'b0}}}) begin
            r.velocity_command = {1'b0, {(VEL_WIDTH-1){1'b1}}};
          end else begin
            r.velocity_command = -home_vel;
          end
          r.use_slew = 1'b1;
        end
      end
    end
    r.status = seq_status;
    return r;
  endfunction

  // Report one field that differs from its expectation.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Watch all three channels; config and tick words update the shadow copy.
  always @(posedge clk) begin
    if (rst) begin
      home_vel      = '0;
      still_thr     = STILL_THRESH_RST;
      still_dwell   = STILL_DWELL_RST;
      backoff_dwell = BACKOFF_DWELL_RST;
      timeout_limit = TIMEOUT_RST;
      seq_status    = STATUS_IDLE;
      reversing     = 1'b0;
      has_moved     = 1'b0;
      rest_cnt      = '0;
      run_ticks     = '0;
      retreat_cnt   = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HOME_VELOCITY: home_vel      = cfg_data;
          CFG_STILL_THRESH:  still_thr     = cfg_data[THR_WIDTH-1:0];
          CFG_STILL_DWELL:   still_dwell   = cfg_data[TICK_WIDTH-1:0];
          CFG_BACKOFF_DWELL: backoff_dwell = cfg_data[TICK_WIDTH-1:0];
          CFG_TIMEOUT:       timeout_limit = cfg_data[TICK_WIDTH-1:0];
          default: ;
        endcase
      end
      if (tick_valid && !tick_stall) expected_q.push_back(homing_step(tick));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word arrived with no tick word waiting for it");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("active", 32'(want.active), 32'(result.active));
          check_field("drive_req", 32'(want.drive_req), 32'(result.drive_req));
          check_field("velocity_command", 32'(want.velocity_command),
                      32'(result.velocity_command));
          check_field("use_slew", 32'(want.use_slew), 32'(result.use_slew));
          check_field("ramp_restart", 32'(want.ramp_restart), 32'(result.ramp_restart));
          check_field("datum_latch", 32'(want.datum_latch), 32'(result.datum_latch));
          check_field("consume_trip", 32'(want.consume_trip), 32'(result.consume_trip));
          check_field("completed", 32'(want.completed), 32'(result.completed));
          check_field("status", 32'(want.status), 32'(result.status));
          checked++;
        end
      end
    end
    fail_count      <= errors;
    outstanding     <= expected_q.size();
    results_checked <= checked;
  end

endmodule

// ===== bench/hard_stop_homing_sequencer_unit_tb.sv =====
// Testbench top for the hard-stop homing sequencer: stimulus, idling and verdict.
`timescale 1ns / 1ps

module hard_stop_homing_sequencer_unit_tb;
  import hshs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 850;

  logic                     clk;
  logic                     rst;
  logic                     tick_valid;
  logic                     tick_stall;
  tick_t                    tick;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [31:0]              cfg_data;

  int fail_count;
  int outstanding;
  int results_checked;

  // Stimulus bookkeeping and the settings currently loaded.
  int                    sent = 0;
  int                    settings_used = 0;
  int                    cycles = 0;
  bit                    quiet = 1'b0;
  logic [THR_WIDTH-1:0]  cur_thr;
  logic [TICK_WIDTH-1:0] cur_sd;
  logic [TICK_WIDTH-1:0] cur_bd;
  logic [TICK_WIDTH-1:0] cur_to;

  hard_stop_homing_sequencer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  hshs_homing_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .tick            (tick),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls at random except during quiet stretches.
  always @(posedge clk) begin
    result_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL hard_stop_homing_sequencer_unit");
      $finish;
    end
  end

  // Clamp a dwell or timeout so that sequences stay short.
  function automatic int short_count(input logic [TICK_WIDTH-1:0] c);
    return (c > 12) ? 12 : int'(c);
  endfunction

  // A velocity whose magnitude is at or below the stillness threshold.
  function automatic logic [31:0] still_vel();
    logic [31:0] mag;
    mag = $urandom_range(0, {1'b0, cur_thr});
    if ($urandom_range(0, 2) == 0) begin
      mag = {1'b0, cur_thr} - ((cur_thr > 3) ? $urandom_range(0, 3) : 0);
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // A velocity whose magnitude exceeds the threshold, often just above it.
  function automatic logic [31:0] moving_vel();
    logic [31:0] lo;
    logic [31:0] mag;
    lo = {1'b0, cur_thr} + 1;
    if ($urandom_range(0, 1) == 0) begin
      mag = lo + $urandom_range(0, ((32'h8000_0000 - lo) > 16) ? 16 : (32'h8000_0000 - lo));
    end else begin
      mag = $urandom_range(lo, 32'h8000_0000);
    end
    if (mag == 32'h8000_0000) return mag;
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // Send one tick word, with an occasional gap before it.
  task automatic push_tick(input logic en, input logic clr, input logic [31:0] vel,
                           input logic trip);
    tick_t w;
    w.enable            = en;
    w.clear             = clr;
    w.measured_velocity = vel;
    w.overcurrent_trip  = trip;
    if (!quiet && $urandom_range(0, 99) < 12) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= w;
    do @(posedge clk); while (tick_stall);
    sent++;
  endtask

  // Write one configuration register; the caller drops valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Return the sequencer to idle and wait until every result word is back.
  task automatic drain();
    push_tick(1'b0, 1'b1, 32'd0, 1'b0);
    tick_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Load a full register setting while the block is idle.
  task automatic load_setting(input logic [31:0] hv, input logic [THR_WIDTH-1:0] thr,
                              input logic [TICK_WIDTH-1:0] sd, input logic [TICK_WIDTH-1:0] bd,
                              input logic [TICK_WIDTH-1:0] to);
    drain();
    write_reg(CFG_HOME_VELOCITY, hv);
    write_reg(CFG_STILL_THRESH, {1'b0, thr});
    write_reg(CFG_STILL_DWELL, {16'd0, sd});
    write_reg(CFG_BACKOFF_DWELL, {16'd0, bd});
    write_reg(CFG_TIMEOUT, {16'd0, to});
    cfg_valid <= 1'b0;
    cur_thr = thr;
    cur_sd  = sd;
    cur_bd  = bd;
    cur_to  = to;
    settings_used++;
  endtask

  // One homing attempt with random content; a few are plain noise or stall out.
  task automatic run_homing();
    int kind;
    int n_move;
    int n_still;
    int n_back;
    int trip_at;
    int abort_at;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 4))
        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                  1'($urandom_range(0, 1)));
      return;
    end
    push_tick(1'b1, 1'($urandom_range(0, 1)),
              $urandom_range(0, 1) ? moving_vel() : still_vel(), kind < 18);
    if (kind < 28) begin
      // Only still velocities follow the starting tick, so the approach ends on the timeout unless it stopped first.
      repeat (short_count(cur_to) + 2) push_tick(1'b1, 1'b0, still_vel(), 1'b0);
    end else begin
      n_move = $urandom_range(1, 4);
      repeat (n_move) push_tick(1'b1, 1'($urandom_range(0, 1)), moving_vel(), 1'b0);
      n_still = short_count(cur_sd) + $urandom_range(0, 1);
      trip_at = (kind < 45) ? $urandom_range(0, n_still) : -1;
      for (int i = 0; i < n_still; i++) begin
        push_tick(1'b1, 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 9) == 0) ? moving_vel() : still_vel(), i == trip_at);
      end
      n_back   = short_count(cur_bd) + $urandom_range(0, 2);
      abort_at = (kind < 55) ? $urandom_range(0, n_back) : -1;
      for (int i = 0; i < n_back; i++) begin
        if (i == abort_at) begin
          push_tick(1'b0, 1'b0, $urandom, 1'($urandom_range(0, 1)));
          break;
        end
        push_tick(1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 7) == 0);
      end
    end
    if ($urandom_range(0, 1)) push_tick(1'b0, 1'b0, $urandom, 1'($urandom_range(0, 1)));
    push_tick(1'b0, 1'b1, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Main stimulus sequence.
  initial begin
    int target;
    int random_start;
    rst        <= 1'b1;
    tick_valid <= 1'b0;
    tick       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_HOME_VELOCITY;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: start and abort once.
    push_tick(1'b0, 1'b0, 32'd0, 1'b0);
    push_tick(1'b1, 1'b0, 32'd0, 1'b0);
    push_tick(1'b0, 1'b0, 32'd0, 1'b0);

    // Directed: short dwells so each path is reached in a few ticks.
    load_setting(32'h0003_0000, 31'd655, 16'd3, 16'd2, 16'd6);
    // Full sequence where the stop lands on the timeout tick, then done held until cleared.
    push_tick(1'b1, 1'b0, 32'd0, 1'b0);
    push_tick(1'b1, 1'b0, 32'h7FFF_FFFF, 1'b0);
    push_tick(1'b1, 1'b0, 32'h8000_0000, 1'b0);
    push_tick(1'b1, 1'b0, 32'd655, 1'b0);
    push_tick(1'b1, 1'b0, -32'sd655, 1'b0);
    push_tick(1'b1, 1'b0, 32'd0, 1'b0);
    push_tick(1'b1, 1'b0, 32'd656, 1'b0);
    push_tick(1'b1, 1'b0, 32'd0, 1'b0);
    push_tick(1'b1, 1'b0, 32'd0, 1'b0);
    push_tick(1'b0, 1'b0, 32'd0, 1'b0);
    push_tick(1'b0, 1'b1, 32'd0, 1'b0);
    // Trip on the starting tick, then abort during back-off.
    push_tick(1'b1, 1'b0, 32'd0, 1'b1);
    push_tick(1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);
    // No motion: timeout gives failed, held while enabled even with clear.
    repeat (6) push_tick(1'b1, 1'b0, -32'sd656 + 32'd1, 1'b0);
    push_tick(1'b1, 1'b1, 32'd0, 1'b0);
    push_tick(1'b0, 1'b1, 32'd0, 1'b0);

    // Random: cycle through settings, extremes first.
    random_start = sent;
    for (int ph = 0; sent - random_start < RANDOM_TICKS; ph++) begin
      case (ph % 8)
        0: load_setting(32'h8000_0000, 31'd0, 16'd0, 16'd0, 16'd1);
        1: load_setting(32'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd1, 16'd1, 16'hFFFF);
        2: load_setting(32'h8000_0000, 31'd655, 16'd4, 16'd3, 16'd30);
        3: load_setting($urandom, 31'($urandom_range(0, 32'h7FFF_FFFF)), 16'hFFFF, 16'hFFFF,
                        16'hFFFF);
        default: load_setting($urandom, 31'($urandom_range(0, 200000)),
                              16'($urandom_range(1, 10)), 16'($urandom_range(1, 8)),
                              16'($urandom_range(8, 60)));
      endcase
      quiet  = (ph % 8 == 5);
      target = sent + 110;
      while (sent < target) run_homing();
    end
    quiet = 1'b0;

    // Let every result word come back, then give the verdict.
    tick_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    $display("Sent %0d tick words across %0d register settings; %0d result words checked.",
             sent, settings_used, results_checked);
    if (fail_count == 0) begin
      $display("PASS hard_stop_homing_sequencer_unit");
    end else begin
      $display("FAIL hard_stop_homing_sequencer_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hshs_pkg.sv
src/hard_stop_homing_sequencer_unit.sv
bench/hshs_homing_checker.sv
bench/hard_stop_homing_sequencer_unit_tb.sv
